### rtl/core/epr_pkg.sv
`default_nettype none

package epr_pkg;

   // Field widths
   localparam int COORD_W = 32;
   localparam int ANGLE_W = 16;
   localparam int TRIG_W  = 16;
   localparam int MAG_W   = 15;

   // Largest table magnitude, the sine at a quarter turn
   localparam logic [MAG_W-1:0] FULL_SCALE = 15'd32767;

   // Pipeline layout: angle-to-trig front end, then three plane rotations
   localparam int TRIG_STAGES = 6;
   localparam int ROT_STAGES  = 2;
   localparam int NSTAGE      = TRIG_STAGES + 3 * ROT_STAGES;
   localparam int ROTX_BASE   = TRIG_STAGES;
   localparam int ROTY_BASE   = TRIG_STAGES + ROT_STAGES;
   localparam int ROTZ_BASE   = TRIG_STAGES + 2 * ROT_STAGES;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [ANGLE_W-1:0] angle_type;
   typedef logic signed [TRIG_W-1:0]  trig_type;
   typedef logic [MAG_W-1:0]          mag_type;

   typedef struct packed {
      trig_type sine;
      trig_type cosine;
   } sincos_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } point_type;

endpackage

`default_nettype wire

### rtl/core/epr_sine_rom.sv
`default_nettype none

// Quarter-wave sine ROM, unsigned Q0.15 magnitudes, two registered read ports.
module epr_sine_rom #(
   parameter int DEPTH = 1024
) (
   input  wire logic                  clock,
   input  wire logic                  rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr_a,
   input  wire logic [$clog2(DEPTH)-1:0] addr_b,
   output epr_pkg::mag_type           data_a,
   output epr_pkg::mag_type           data_b
);

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
   localparam logic [63:0] SERIES_DIV [6] = '{64'd156, 64'd110, 64'd72,
                                              64'd42, 64'd20, 64'd6};

   typedef epr_pkg::mag_type rom_type [DEPTH];

   // Taylor series in Horner form, Q30
   function automatic rom_type build_rom();
      rom_type     rom;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] e;
      for (int k = 0; k < DEPTH; k++) begin
         x  = (64'(k) * HALF_PI_Q30) / DEPTH;
         x2 = (x * x) >> 30;
         t  = ONE_Q30;
         for (int i = 0; i < 6; i++) begin
            t = ONE_Q30 - (((x2 * t) >> 30) / SERIES_DIV[i]);
         end
         s = (x * t) >> 30;
         e = (s + (64'd1 << 14)) >> 15;
         if (e > 64'(epr_pkg::FULL_SCALE)) begin
            e = 64'(epr_pkg::FULL_SCALE);
         end
         rom[k] = epr_pkg::MAG_W'(e);
      end
      return rom;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   epr_pkg::mag_type data_a_ff;
   epr_pkg::mag_type data_b_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         data_a_ff <= SINE_ROM[addr_a];
         data_b_ff <= SINE_ROM[addr_b];
      end
   end

   assign data_a = data_a_ff;
   assign data_b = data_b_ff;

endmodule

`default_nettype wire

### rtl/core/epr_trig.sv
`default_nettype none

// Angle (Q3.12 rad) to sine and cosine (Q1.15), six stages.
module epr_trig #(
   parameter int DEPTH = 1024
) (
   input  wire logic                 clock,
   input  wire logic [epr_pkg::TRIG_STAGES-1:0] stage_en,
   input  wire epr_pkg::angle_type   angle,
   output epr_pkg::sincos_type       trig
);

   localparam int IW = $clog2(DEPTH);
   localparam int FW = $clog2(4 * DEPTH);
   localparam int PW = $clog2(8 * DEPTH);
   localparam int MW = epr_pkg::ANGLE_W + 1;
   localparam int HW = 24;
   localparam int PPW = MW + HW;
   localparam int SW = PPW + HW + 1;

   localparam logic [63:0] INV_PI_Q32 = 64'd1367130551;
   localparam logic [63:0] SCALE      = 64'(2 * DEPTH) * INV_PI_Q32;
   localparam logic [HW-1:0] SCALE_LO = SCALE[HW-1:0];
   localparam logic [HW-1:0] SCALE_HI = SCALE[2*HW-1:HW];
   localparam logic [PW-1:0] FULL_P   = PW'(4 * DEPTH);
   localparam logic [FW-1:0] QUAD1    = FW'(DEPTH);
   localparam logic [FW-1:0] QUAD2    = FW'(2 * DEPTH);
   localparam logic [FW-1:0] QUAD3    = FW'(3 * DEPTH);

   // stage 0: magnitude times 2D/pi, split in two partial products
   logic [MW-1:0]  mag;
   logic [PPW-1:0] pp_lo_in, pp_hi_in, pp_lo_ff, pp_hi_ff;
   logic           neg0_ff;
   // stage 1: rounded phase
   logic [SW-1:0]  sum;
   logic [PW-1:0]  p_in, p_ff;
   logic           neg1_ff;
   // stage 2: wrapped signed phase
   logic [PW-1:0]  p_wrap;
   logic [FW-1:0]  ph_in, ph_ff;
   // stage 3: quadrant and table addresses
   logic [1:0]     q_in, q3_ff, q4_ff;
   logic [FW-1:0]  base, rem, rem_b;
   logic [IW-1:0]  addr_a_in, addr_b_in, addr_a_ff, addr_b_ff;
   logic           full_in, full3_ff, full4_ff;
   // stage 4: ROM data
   epr_pkg::mag_type la, lb;
   // stage 5: signed outputs
   epr_pkg::mag_type lb_fs, sin_mag, cos_mag;
   epr_pkg::sincos_type trig_in, trig_ff;

   always_comb begin
      mag      = angle[epr_pkg::ANGLE_W-1] ? (MW'(0) - MW'(angle)) : MW'(angle);
      pp_lo_in = PPW'(mag) * PPW'(SCALE_LO);
      pp_hi_in = PPW'(mag) * PPW'(SCALE_HI);
   end

   always_comb begin
      sum  = {1'b0, pp_hi_ff, {HW{1'b0}}} + SW'(pp_lo_ff) + (SW'(1) << 43);
      p_in = sum[44 +: PW];
   end

   always_comb begin
      p_wrap = (p_ff >= FULL_P) ? (p_ff - FULL_P) : p_ff;
      if (neg1_ff && (p_wrap != '0)) begin
         ph_in = FW'(FULL_P - p_wrap);
      end else begin
         ph_in = FW'(p_wrap);
      end
   end

   // cosine sits one quadrant ahead with the same remainder, so both
   // lookups share the pair L(r), L(D-r)
   always_comb begin
      if (ph_ff >= QUAD3) begin
         q_in = 2'd3;
         base = QUAD3;
      end else if (ph_ff >= QUAD2) begin
         q_in = 2'd2;
         base = QUAD2;
      end else if (ph_ff >= QUAD1) begin
         q_in = 2'd1;
         base = QUAD1;
      end else begin
         q_in = 2'd0;
         base = '0;
      end
      rem       = ph_ff - base;
      rem_b     = QUAD1 - rem;
      addr_a_in = IW'(rem);
      addr_b_in = IW'(rem_b);
      full_in   = (rem == '0);
   end

   epr_sine_rom #(
      .DEPTH (DEPTH)
   ) u_rom (
      .clock  (clock),
      .rd_en  (stage_en[4]),
      .addr_a (addr_a_ff),
      .addr_b (addr_b_ff),
      .data_a (la),
      .data_b (lb)
   );

   always_comb begin
      lb_fs   = full4_ff ? epr_pkg::FULL_SCALE : lb;
      sin_mag = q4_ff[0] ? lb_fs : la;
      cos_mag = q4_ff[0] ? la : lb_fs;
      trig_in.sine   = q4_ff[1] ? -epr_pkg::TRIG_W'(sin_mag)
                                :  epr_pkg::TRIG_W'(sin_mag);
      trig_in.cosine = (q4_ff[1] ^ q4_ff[0]) ? -epr_pkg::TRIG_W'(cos_mag)
                                             :  epr_pkg::TRIG_W'(cos_mag);
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         pp_lo_ff <= pp_lo_in;
         pp_hi_ff <= pp_hi_in;
         neg0_ff  <= angle[epr_pkg::ANGLE_W-1];
      end
      if (stage_en[1]) begin
         p_ff    <= p_in;
         neg1_ff <= neg0_ff;
      end
      if (stage_en[2]) begin
         ph_ff <= ph_in;
      end
      if (stage_en[3]) begin
         q3_ff     <= q_in;
         addr_a_ff <= addr_a_in;
         addr_b_ff <= addr_b_in;
         full3_ff  <= full_in;
      end
      if (stage_en[4]) begin
         q4_ff    <= q3_ff;
         full4_ff <= full3_ff;
      end
      if (stage_en[5]) begin
         trig_ff <= trig_in;
      end
   end

   assign trig = trig_ff;

endmodule

`default_nettype wire

### rtl/core/epr_rotate.sv
`default_nettype none

// One plane rotation: a' = a*c - b*s, b' = a*s + b*c, Q16.16 saturated.
// Stage 0 forms the four products, stage 1 sums, shifts and saturates.
module epr_rotate #(
   parameter int SIDE_W = 32
) (
   input  wire logic                       clock,
   input  wire logic [epr_pkg::ROT_STAGES-1:0] stage_en,
   input  wire epr_pkg::coord_type         src_a,
   input  wire epr_pkg::coord_type         src_b,
   input  wire epr_pkg::sincos_type        src_trig,
   input  wire logic [SIDE_W-1:0]          src_side,
   output epr_pkg::coord_type              dst_a,
   output epr_pkg::coord_type              dst_b,
   output logic [SIDE_W-1:0]               dst_side
);

   localparam int PRW = epr_pkg::COORD_W + epr_pkg::TRIG_W;
   localparam int SUW = PRW + 1;
   localparam int SHW = SUW - 15;

   localparam epr_pkg::coord_type COORD_MAX = {1'b0, {(epr_pkg::COORD_W-1){1'b1}}};
   localparam epr_pkg::coord_type COORD_MIN = {1'b1, {(epr_pkg::COORD_W-1){1'b0}}};

   function automatic epr_pkg::coord_type shift_sat(input logic signed [SUW-1:0] v);
      logic signed [SHW-1:0] sh;
      sh = v[SUW-1:15];
      if (sh[SHW-1:epr_pkg::COORD_W-1] == '0 || sh[SHW-1:epr_pkg::COORD_W-1] == '1) begin
         return sh[epr_pkg::COORD_W-1:0];
      end
      return sh[SHW-1] ? COORD_MIN : COORD_MAX;
   endfunction

   logic signed [PRW-1:0] ac_in, bs_in, as_in, bc_in;
   logic signed [PRW-1:0] ac_ff, bs_ff, as_ff, bc_ff;
   logic [SIDE_W-1:0]     side0_ff, side1_ff;
   logic signed [SUW-1:0] diff, total;
   epr_pkg::coord_type    a_in, b_in, a_ff, b_ff;

   always_comb begin
      ac_in = PRW'(src_a) * PRW'(src_trig.cosine);
      bs_in = PRW'(src_b) * PRW'(src_trig.sine);
      as_in = PRW'(src_a) * PRW'(src_trig.sine);
      bc_in = PRW'(src_b) * PRW'(src_trig.cosine);
   end

   always_comb begin
      diff  = SUW'(ac_ff) - SUW'(bs_ff);
      total = SUW'(as_ff) + SUW'(bc_ff);
      a_in  = shift_sat(diff);
      b_in  = shift_sat(total);
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         ac_ff    <= ac_in;
         bs_ff    <= bs_in;
         as_ff    <= as_in;
         bc_ff    <= bc_in;
         side0_ff <= src_side;
      end
      if (stage_en[1]) begin
         a_ff     <= a_in;
         b_ff     <= b_in;
         side1_ff <= side0_ff;
      end
   end

   assign dst_a    = a_ff;
   assign dst_b    = b_ff;
   assign dst_side = side1_ff;

endmodule

`default_nettype wire

### rtl/core/euler_point_rotate_3d.sv
// Rotates a 3D point about X, then Y, then Z.
// Request word: point_x/y/z in signed Q16.16, angle_x/y/z in signed Q3.12
// radians. Response word: rotated_x/y/z in signed Q16.16, saturated per axis
// after every rotation step. Products are floored by an arithmetic shift.
// Both channels are valid/ready; a word moves when valid and ready are high.
// From request to response, each word passes the sine/cosine front end that
// turns the three angles into sine/cosine (phase scale, wrap, quadrant decode,
// ROM read, sign), then each plane rotation (products, then sum/shift/saturate).
// One word enters per cycle while req_ready is high.
// Trig tables: one quarter-wave ROM of SINE_TABLE_DEPTH entries per angle,
// each with two read ports (L(r) and L(D-r) serve sine and cosine).
// Each stage carries a valid bit and advances when it is empty or the next
// stage advances, so a stalled receiver freezes only the full tail of the
// pipe; req_ready stays high while any stage holds a bubble. Nothing is lost
// or repeated under stalls. Reset (synchronous, active high) empties the pipe.
`default_nettype none

module euler_point_rotate_3d #(
   parameter int SINE_TABLE_DEPTH = 1024
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire epr_pkg::coord_type  req_point_x,
   input  wire epr_pkg::coord_type  req_point_y,
   input  wire epr_pkg::coord_type  req_point_z,
   input  wire epr_pkg::angle_type  req_angle_x,
   input  wire epr_pkg::angle_type  req_angle_y,
   input  wire epr_pkg::angle_type  req_angle_z,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output epr_pkg::coord_type       rsp_rotated_x,
   output epr_pkg::coord_type       rsp_rotated_y,
   output epr_pkg::coord_type       rsp_rotated_z
);

   localparam int NS = epr_pkg::NSTAGE;
   localparam int TS = epr_pkg::TRIG_STAGES;
   localparam int RS = epr_pkg::ROT_STAGES;
   localparam int SC_W = $bits(epr_pkg::sincos_type);
   localparam int CW = epr_pkg::COORD_W;
   localparam logic [NS-1:0] ALL_VALID = '1;

   logic [NS-1:0] valid_in, valid_ff;
   logic [NS-1:0] stage_en;

   // stage k moves when it or any stage after it is empty, or the
   // receiver takes the last word
   always_comb begin
      for (int k = 0; k < NS; k++) begin
         stage_en[k] = rsp_ready || ((valid_ff >> k) != (ALL_VALID >> k));
         if (stage_en[k]) begin
            valid_in[k] = (k == 0) ? req_valid : valid_ff[(k == 0) ? 0 : k-1];
         end else begin
            valid_in[k] = valid_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // point travels beside the trig front end
   epr_pkg::point_type pt_in [TS];
   epr_pkg::point_type pt_ff [TS];

   always_comb begin
      pt_in[0].x = req_point_x;
      pt_in[0].y = req_point_y;
      pt_in[0].z = req_point_z;
      for (int k = 1; k < TS; k++) begin
         pt_in[k] = pt_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < TS; k++) begin
         if (stage_en[k]) begin
            pt_ff[k] <= pt_in[k];
         end
      end
   end

   epr_pkg::sincos_type trig_x, trig_y, trig_z;

   epr_trig #(.DEPTH (SINE_TABLE_DEPTH)) u_trig_x (
      .clock    (clock),
      .stage_en (stage_en[TS-1:0]),
      .angle    (req_angle_x),
      .trig     (trig_x)
   );

   epr_trig #(.DEPTH (SINE_TABLE_DEPTH)) u_trig_y (
      .clock    (clock),
      .stage_en (stage_en[TS-1:0]),
      .angle    (req_angle_y),
      .trig     (trig_y)
   );

   epr_trig #(.DEPTH (SINE_TABLE_DEPTH)) u_trig_z (
      .clock    (clock),
      .stage_en (stage_en[TS-1:0]),
      .angle    (req_angle_z),
      .trig     (trig_z)
   );

   // X: (y, z) rotate; x and the later trig words ride along
   epr_pkg::coord_type x1_y, x1_z;
   logic [CW+2*SC_W-1:0] x1_side;

   epr_rotate #(.SIDE_W (CW + 2*SC_W)) u_rot_x (
      .clock    (clock),
      .stage_en (stage_en[epr_pkg::ROTX_BASE +: RS]),
      .src_a    (pt_ff[TS-1].y),
      .src_b    (pt_ff[TS-1].z),
      .src_trig (trig_x),
      .src_side ({pt_ff[TS-1].x, trig_y, trig_z}),
      .dst_a    (x1_y),
      .dst_b    (x1_z),
      .dst_side (x1_side)
   );

   // Y: (z, x) rotate
   epr_pkg::coord_type  y2_z, y2_x;
   epr_pkg::coord_type  x1_x;
   epr_pkg::sincos_type x1_trig_y, x1_trig_z;
   logic [CW+SC_W-1:0]  y2_side;

   assign {x1_x, x1_trig_y, x1_trig_z} = x1_side;

   epr_rotate #(.SIDE_W (CW + SC_W)) u_rot_y (
      .clock    (clock),
      .stage_en (stage_en[epr_pkg::ROTY_BASE +: RS]),
      .src_a    (x1_z),
      .src_b    (x1_x),
      .src_trig (x1_trig_y),
      .src_side ({x1_y, x1_trig_z}),
      .dst_a    (y2_z),
      .dst_b    (y2_x),
      .dst_side (y2_side)
   );

   // Z: (x, y) rotate; final z rides along
   epr_pkg::coord_type  y2_y;
   epr_pkg::sincos_type y2_trig_z;
   logic [CW-1:0]       z3_side;

   assign {y2_y, y2_trig_z} = y2_side;

   epr_rotate #(.SIDE_W (CW)) u_rot_z (
      .clock    (clock),
      .stage_en (stage_en[epr_pkg::ROTZ_BASE +: RS]),
      .src_a    (y2_x),
      .src_b    (y2_y),
      .src_trig (y2_trig_z),
      .src_side (y2_z),
      .dst_a    (rsp_rotated_x),
      .dst_b    (rsp_rotated_y),
      .dst_side (z3_side)
   );

   assign rsp_rotated_z = z3_side;
   assign rsp_valid     = valid_ff[NS-1];
   assign req_ready     = stage_en[0];

   // any bubble in the pipe must open the request side
   assert property (@(posedge clock) disable iff (reset)
      (valid_ff != ALL_VALID) |-> req_ready)
      else $error("request side blocked with a bubble in the pipe");

   // words in flight change only by accepted requests and taken responses
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |->
         ($countones(valid_ff) == $countones($past(valid_ff))
            + $past(req_valid && req_ready) - $past(rsp_valid && rsp_ready)))
      else $error("pipeline word count out of balance");

   // an accepted request lands in the first stage
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> valid_ff[0])
      else $error("accepted request not captured");

   // a full last stage that is held keeps its word
   assert property (@(posedge clock) disable iff (reset)
      (valid_ff[NS-1] && !stage_en[NS-1]) |=> valid_ff[NS-1])
      else $error("held response word dropped");

endmodule

`default_nettype wire
